// ----- rtl/walsh_code_despreader_macros.svh -----
// ----------------------------------------------------------------------------
// Walsh code despreader assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef WALSH_CODE_DESPREADER_MACROS_SVH
`define WALSH_CODE_DESPREADER_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define WCD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define WCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/wcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Walsh code despreader package
// Widths, register indexes and shared types of the despreader.
// ----------------------------------------------------------------------------
package wcd_pkg;

  localparam int CHIP_W       = 8;
  localparam int SYM_W        = 8;
  localparam int SLOT_W       = 3;
  localparam int CODE_W       = 3;
  localparam int SIDX_W       = 12;
  localparam int FS_W         = 13;
  localparam int MAX_USERS    = 8;
  localparam int CODE_LEN_DEF = 8;
  localparam int FRAME_MAX    = 4096;
  localparam int FS_RESET     = 16;
  localparam int QUEUE_DEPTH  = 2;
  localparam int APB_DW       = 32;
  localparam int PADDR_W      = 3;
  localparam int REG_IDX_W    = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_SYMBOLS = '0;

  // Per-block classification that travels with the snapshot of the sums.
  typedef struct packed {
    logic [MAX_USERS-1:0] mask;
    logic [SIDX_W-1:0]    sym_idx;
  } blk_info_t;

  function automatic int num_users(int code_len);
    return (code_len < MAX_USERS) ? code_len : MAX_USERS;
  endfunction

  function automatic int sum_width(int code_len);
    return CHIP_W + $clog2(code_len);
  endfunction

endpackage

// ----- rtl/wcd_ifs.sv -----
// ----------------------------------------------------------------------------
// Walsh code despreader stream interfaces
// Valid/ready channels for received chips and for despread symbols.
// ----------------------------------------------------------------------------
interface wcd_chip_if;
  logic                                valid;
  logic                                ready;
  logic signed [wcd_pkg::CHIP_W-1:0]   chip;

  modport source (output valid, output chip, input ready);
  modport sink   (input valid, input chip, output ready);
endinterface

interface wcd_res_if;
  logic                                valid;
  logic                                ready;
  logic        [wcd_pkg::SLOT_W-1:0]   user_slot;
  logic        [wcd_pkg::CODE_W-1:0]   user_code;
  logic signed [wcd_pkg::SYM_W-1:0]    symbol;
  logic        [wcd_pkg::SIDX_W-1:0]   symbol_index;
  logic                                last;

  modport source (output valid, output user_slot, output user_code, output symbol,
                  output symbol_index, output last, input ready);
  modport sink   (input valid, input user_slot, input user_code, input symbol,
                  input symbol_index, input last, output ready);
endinterface

// ----- rtl/wcd_fifo.sv -----
// ----------------------------------------------------------------------------
// Walsh code despreader block queue
// Small register queue between the correlator front and the symbol back.
// ----------------------------------------------------------------------------
module wcd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/wcd_front.sv -----
// ----------------------------------------------------------------------------
// Walsh code despreader front end
// Accepts chips, runs one correlator lane per user code and, at the end of
// each chip block, classifies the active users and hands the sums on.
// ----------------------------------------------------------------------------
module wcd_front #(
  parameter int CODE_LEN  = wcd_pkg::CODE_LEN_DEF,
  parameter int NUM_USERS = wcd_pkg::num_users(CODE_LEN),
  parameter int SUM_W     = wcd_pkg::sum_width(CODE_LEN)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  wcd_chip_if.sink                          in_i,
  input  logic [wcd_pkg::FS_W-1:0]          frame_symbols_i,
  output logic                              blk_valid_o,
  input  logic                              blk_ready_i,
  output logic [NUM_USERS-1:0][SUM_W-1:0]   blk_sums_o,
  output wcd_pkg::blk_info_t                blk_info_o
);

  localparam int CP_W  = $clog2(CODE_LEN);
  localparam int PAR_W = CP_W + wcd_pkg::CODE_W;
  localparam logic signed [SUM_W-1:0] LEN_S = SUM_W'(CODE_LEN);

  logic signed [SUM_W-1:0]            sums_q [NUM_USERS];
  logic signed [SUM_W-1:0]            sums_nxt [NUM_USERS];
  logic        [CP_W-1:0]             chip_pos_q;
  logic        [wcd_pkg::SIDX_W-1:0]  sym_pos_q, sym_pos_d;
  logic        [wcd_pkg::MAX_USERS-1:0] act_q, act_new, nz_mask;
  logic signed [SUM_W-1:0]            chip_ext;
  logic                               last_chip;
  logic                               take;
  logic        [wcd_pkg::FS_W-1:0]    frame_len;
  logic        [wcd_pkg::FS_W-1:0]    sym_pos_inc;

  assign chip_ext  = SUM_W'(in_i.chip);
  assign last_chip = (chip_pos_q == CP_W'(CODE_LEN - 1));
  assign in_i.ready = !(last_chip && !blk_ready_i);
  assign take      = in_i.valid && in_i.ready;

  // One add/subtract lane per user code; the sign follows the Hadamard row.
  for (genvar g = 0; g < wcd_pkg::MAX_USERS; g++) begin : g_lane
    if (g < NUM_USERS) begin : g_used
      logic [PAR_W-1:0] row_bits;
      logic             minus;
      assign row_bits    = PAR_W'(g) & PAR_W'(chip_pos_q);
      assign minus       = ^row_bits;
      assign sums_nxt[g] = minus ? (sums_q[g] - chip_ext) : (sums_q[g] + chip_ext);
      assign nz_mask[g]  = (sums_nxt[g] >= LEN_S) || (sums_nxt[g] <= -LEN_S);
      assign blk_sums_o[g] = sums_nxt[g];
    end else begin : g_unused
      assign nz_mask[g] = 1'b0;
    end
  end

  // The first block of a frame decides the active set for the whole frame.
  assign act_new = (sym_pos_q == '0) ? nz_mask : act_q;

  always_comb begin
    if (frame_symbols_i == '0) begin
      frame_len = wcd_pkg::FS_W'(1);
    end else if (frame_symbols_i > wcd_pkg::FS_W'(wcd_pkg::FRAME_MAX)) begin
      frame_len = wcd_pkg::FS_W'(wcd_pkg::FRAME_MAX);
    end else begin
      frame_len = frame_symbols_i;
    end
    sym_pos_inc = wcd_pkg::FS_W'(sym_pos_q) + wcd_pkg::FS_W'(1);
    sym_pos_d   = (sym_pos_inc >= frame_len) ? '0 : sym_pos_inc[wcd_pkg::SIDX_W-1:0];
  end

  assign blk_valid_o        = take && last_chip && (act_new != '0);
  assign blk_info_o.mask    = act_new;
  assign blk_info_o.sym_idx = sym_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_pos_q <= '0;
      sym_pos_q  <= '0;
      act_q      <= '0;
      for (int i = 0; i < NUM_USERS; i++) begin
        sums_q[i] <= '0;
      end
    end else if (take) begin
      if (last_chip) begin
        chip_pos_q <= '0;
        sym_pos_q  <= sym_pos_d;
        act_q      <= act_new;
        for (int i = 0; i < NUM_USERS; i++) begin
          sums_q[i] <= '0;
        end
      end else begin
        chip_pos_q <= chip_pos_q + CP_W'(1);
        for (int i = 0; i < NUM_USERS; i++) begin
          sums_q[i] <= sums_nxt[i];
        end
      end
    end
  end

endmodule

// ----- rtl/wcd_back.sv -----
// ----------------------------------------------------------------------------
// Walsh code despreader back end
// Walks the active users of each queued block, divides each sum by the code
// length and saturates it, and presents one symbol word per cycle unless stalled.
// ----------------------------------------------------------------------------
module wcd_back #(
  parameter int CODE_LEN  = wcd_pkg::CODE_LEN_DEF,
  parameter int NUM_USERS = wcd_pkg::num_users(CODE_LEN),
  parameter int SUM_W     = wcd_pkg::sum_width(CODE_LEN)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              head_valid_i,
  input  logic [NUM_USERS-1:0][SUM_W-1:0]   head_sums_i,
  input  wcd_pkg::blk_info_t                head_info_i,
  output logic                              pop_o,
  wcd_res_if.source                         res_o
);

  // Division by the code length is a multiply by a rounded-up reciprocal,
  // exact for every magnitude that fits in SUM_W bits.
  localparam int SHIFT   = SUM_W + $clog2(CODE_LEN);
  localparam int RECIP_W = SHIFT + 1;
  localparam int unsigned RECIP = ((32'd1 << SHIFT) + CODE_LEN - 1) / CODE_LEN;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int MAG_W   = wcd_pkg::SYM_W + 1;
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(1) << (wcd_pkg::SYM_W - 1);
  localparam logic [MAG_W-1:0] POS_LIM = NEG_LIM - MAG_W'(1);
  localparam int MU = wcd_pkg::MAX_USERS;

  logic [MU-1:0]                 rem_q, sel_mask, pick_bit, rem_nxt;
  logic                          started_q;
  logic [wcd_pkg::SLOT_W-1:0]    slot_q;
  logic [wcd_pkg::CODE_W-1:0]    pick;
  logic                          pick_last;
  logic signed [SUM_W-1:0]       sel_sum;
  logic                          sel_neg;
  logic [SUM_W-1:0]              sel_mag;
  logic [PROD_W-1:0]             prod;
  logic                          issue, adv1, adv2;

  logic                          v1_q;
  logic [PROD_W-1:0]             prod_q;
  logic                          neg1_q, last1_q;
  logic [wcd_pkg::CODE_W-1:0]    code1_q;
  logic [wcd_pkg::SLOT_W-1:0]    slot1_q;
  logic [wcd_pkg::SIDX_W-1:0]    sidx1_q;

  logic                          ov_q;
  logic [wcd_pkg::SLOT_W-1:0]    slot2_q;
  logic [wcd_pkg::CODE_W-1:0]    code2_q;
  logic signed [wcd_pkg::SYM_W-1:0] sym2_q, sym_d;
  logic [wcd_pkg::SIDX_W-1:0]    sidx2_q;
  logic                          last2_q;
  logic [MAG_W-1:0]              qmag, qneg;

  assign adv2  = !ov_q || res_o.ready;
  assign adv1  = !v1_q || adv2;
  assign issue = head_valid_i && adv1;

  assign sel_mask = started_q ? rem_q : head_info_i.mask;

  // Lowest remaining active user goes next.
  always_comb begin
    pick = '0;
    for (int i = NUM_USERS - 1; i >= 0; i--) begin
      if (sel_mask[i]) begin
        pick = wcd_pkg::CODE_W'(i);
      end
    end
  end

  assign pick_bit  = MU'(1) << pick;
  assign rem_nxt   = sel_mask & ~pick_bit;
  assign pick_last = (rem_nxt == '0);
  assign pop_o     = issue && pick_last;

  always_comb begin
    sel_sum = '0;
    for (int i = 0; i < NUM_USERS; i++) begin
      if (pick == wcd_pkg::CODE_W'(i)) begin
        sel_sum = head_sums_i[i];
      end
    end
  end

  assign sel_neg = sel_sum[SUM_W-1];
  assign sel_mag = sel_neg ? (~sel_sum + SUM_W'(1)) : sel_sum;
  assign prod    = PROD_W'(sel_mag) * PROD_W'(RECIP_C);

  // Quotient magnitude, then sign and saturation to the symbol range.
  assign qmag = prod_q[SHIFT +: MAG_W];
  assign qneg = ~qmag + MAG_W'(1);

  always_comb begin
    if (neg1_q) begin
      sym_d = (qmag > NEG_LIM) ? wcd_pkg::SYM_W'(NEG_LIM) : qneg[wcd_pkg::SYM_W-1:0];
    end else begin
      sym_d = (qmag > POS_LIM) ? POS_LIM[wcd_pkg::SYM_W-1:0] : qmag[wcd_pkg::SYM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      rem_q     <= '0;
      slot_q    <= '0;
      v1_q      <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      if (issue) begin
        if (pick_last) begin
          started_q <= 1'b0;
          slot_q    <= '0;
        end else begin
          started_q <= 1'b1;
          rem_q     <= rem_nxt;
          slot_q    <= slot_q + wcd_pkg::SLOT_W'(1);
        end
      end
      if (adv1) begin
        v1_q <= issue;
      end
      if (adv2) begin
        ov_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      prod_q  <= prod;
      neg1_q  <= sel_neg;
      code1_q <= pick;
      slot1_q <= slot_q;
      sidx1_q <= head_info_i.sym_idx;
      last1_q <= pick_last;
    end
    if (adv2 && v1_q) begin
      slot2_q <= slot1_q;
      code2_q <= code1_q;
      sym2_q  <= sym_d;
      sidx2_q <= sidx1_q;
      last2_q <= last1_q;
    end
  end

  assign res_o.valid        = ov_q;
  assign res_o.user_slot    = slot2_q;
  assign res_o.user_code    = code2_q;
  assign res_o.symbol       = sym2_q;
  assign res_o.symbol_index = sidx2_q;
  assign res_o.last         = last2_q;

endmodule

// ----- rtl/walsh_code_despreader.sv -----
// ----------------------------------------------------------------------------
// Walsh code despreader
// CDMA despreader correlating chip blocks against Sylvester Hadamard rows.
// ----------------------------------------------------------------------------
// Usage: received chips enter on in_i, one signed 8-bit chip per word. Every
// CODE_LEN chips form a block that is correlated with Hadamard rows 0 up to
// min(CODE_LEN, 8) - 1. The first block of a frame selects the active users,
// those whose symbol is non-zero; every block of the frame, the first one too,
// yields one symbol word on res_o for every active user, in rising code order,
// with the last word of the block flagged. A block with no active user yields
// nothing. The frame length in symbols is set over APB at address 0; the user
// must see it written only while the block is idle; the block does not check.
// Flow: the first symbol word of a block passes the block queue, the product
// register and the output register; the others follow one per cycle while
// the receiver takes them. The front takes one chip per cycle when not stalled;
// the back emits one word per cycle while the receiver does not hold off,
// limited by its single reciprocal multiplier. A two-entry block queue lets
// the two sides run apart; the front stalls on a block's last chip only when the
// queue is full. When the receiver holds off, the output word stays put.
// Reset clears the sums, the positions, the active set and all valid flags,
// and sets the frame length to 16 symbols.
// ----------------------------------------------------------------------------
module walsh_code_despreader #(
  parameter int CODE_LEN = wcd_pkg::CODE_LEN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wcd_chip_if.sink                      in_i,
  wcd_res_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wcd_pkg::PADDR_W-1:0]   paddr,
  input  logic [wcd_pkg::APB_DW-1:0]    pwdata,
  output logic [wcd_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int NUM_USERS = wcd_pkg::num_users(CODE_LEN);
  localparam int SUM_W     = wcd_pkg::sum_width(CODE_LEN);
  localparam int SNAP_W    = NUM_USERS * SUM_W;
  localparam int ENTRY_W   = SNAP_W + $bits(wcd_pkg::blk_info_t);

  logic [wcd_pkg::FS_W-1:0]            frame_symbols_q;
  logic                                cfg_wr;
  logic                                blk_valid, q_full, q_empty, q_pop;
  logic [NUM_USERS-1:0][SUM_W-1:0]     blk_sums, head_sums;
  wcd_pkg::blk_info_t                  blk_info, head_info;
  logic [ENTRY_W-1:0]                  push_data, head_data;

  // Configuration: a single frame length register; other addresses ignore
  // writes and read as zero.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[wcd_pkg::PADDR_W-1:2] == wcd_pkg::REG_FRAME_SYMBOLS);
  assign prdata = (paddr[wcd_pkg::PADDR_W-1:2] == wcd_pkg::REG_FRAME_SYMBOLS) ?
                  wcd_pkg::APB_DW'(frame_symbols_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_symbols_q <= wcd_pkg::FS_W'(wcd_pkg::FS_RESET);
    end else if (cfg_wr) begin
      frame_symbols_q <= pwdata[wcd_pkg::FS_W-1:0];
    end
  end

  wcd_front #(
    .CODE_LEN  (CODE_LEN),
    .NUM_USERS (NUM_USERS),
    .SUM_W     (SUM_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_i            (in_i),
    .frame_symbols_i (frame_symbols_q),
    .blk_valid_o     (blk_valid),
    .blk_ready_i     (!q_full),
    .blk_sums_o      (blk_sums),
    .blk_info_o      (blk_info)
  );

  // Each queue entry holds the final sums of one block, its active set and its symbol index.
  assign push_data = {blk_info, blk_sums};
  assign head_sums = head_data[SNAP_W-1:0];
  assign head_info = head_data[ENTRY_W-1:SNAP_W];

  wcd_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (wcd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (blk_valid),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (head_data),
    .empty_o     (q_empty)
  );

  wcd_back #(
    .CODE_LEN  (CODE_LEN),
    .NUM_USERS (NUM_USERS),
    .SUM_W     (SUM_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .head_sums_i  (head_sums),
    .head_info_i  (head_info),
    .pop_o        (q_pop),
    .res_o        (res_o)
  );

endmodule

// ----- rtl/wcd_checker.sv -----
// ----------------------------------------------------------------------------
// Walsh code despreader port checker
// Watches the result channel of the despreader over time.
// ----------------------------------------------------------------------------
`include "walsh_code_despreader_macros.svh"

module wcd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [wcd_pkg::SLOT_W-1:0]    res_user_slot_i,
  input logic [wcd_pkg::CODE_W-1:0]    res_user_code_i,
  input logic [wcd_pkg::SYM_W-1:0]     res_symbol_i,
  input logic [wcd_pkg::SIDX_W-1:0]    res_symbol_index_i,
  input logic                          res_last_i
);

  // A stalled word keeps its content.
  property p_hold;
    res_valid_i && !res_ready_i |=>
      res_valid_i && $stable(res_symbol_i) && $stable(res_user_code_i) &&
      $stable(res_user_slot_i) && $stable(res_symbol_index_i) && $stable(res_last_i);
  endproperty

  // Compaction never moves a user above its own code.
  property p_slot_le_code;
    res_valid_i |-> res_user_slot_i <= res_user_code_i;
  endproperty

  // Inside a block, slots count up by one, codes rise and the index stays.
  property p_block_order;
    res_valid_i && res_ready_i && !res_last_i |=> !res_valid_i ||
      (res_symbol_index_i == $past(res_symbol_index_i) &&
       res_user_slot_i == $past(res_user_slot_i) + wcd_pkg::SLOT_W'(1) &&
       res_user_code_i > $past(res_user_code_i));
  endproperty

  // A new block starts again at slot zero.
  property p_block_start;
    res_valid_i && res_ready_i && res_last_i |=> !res_valid_i || res_user_slot_i == '0;
  endproperty

  `WCD_ASSERT(a_hold, clk_i, rst_ni, p_hold, "result word changed while stalled")
  `WCD_ASSERT(a_slot_le_code, clk_i, rst_ni, p_slot_le_code, "slot above code")
  `WCD_ASSERT(a_block_order, clk_i, rst_ni, p_block_order, "block order broken")
  `WCD_ASSERT(a_block_start, clk_i, rst_ni, p_block_start, "block does not start at slot zero")

  // Nothing is offered while reset is held.
  `WCD_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !res_valid_i, "result valid during reset")

endmodule

bind walsh_code_despreader wcd_checker u_wcd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .res_valid_i        (res_o.valid),
  .res_ready_i        (res_o.ready),
  .res_user_slot_i    (res_o.user_slot),
  .res_user_code_i    (res_o.user_code),
  .res_symbol_i       (res_o.symbol),
  .res_symbol_index_i (res_o.symbol_index),
  .res_last_i         (res_o.last)
);

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Walsh code despreader testbench
// Feeds signed chips through the despreader in bursts with random gaps while
// the symbol receiver stalls on a pattern of its own. A short table of chip
// blocks with hand-computed symbols opens the run. Random phases follow, each
// with its own frame length written over APB while the block is idle. Every
// symbol word is checked field by field against an in-bench correlator model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wcd_pkg::*;

  localparam int CODE_LEN     = CODE_LEN_DEF;
  // Only the first min(CODE_LEN, 8) Hadamard rows carry a user.
  localparam int USERS        = (CODE_LEN < MAX_USERS) ? CODE_LEN : MAX_USERS;
  localparam logic [MAX_USERS-1:0] USER_BITS =
    (USERS >= MAX_USERS) ? '1 : MAX_USERS'((1 << USERS) - 1);
  // Spare register index: nothing is mapped there, so writes must be dropped.
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 1'b1;
  localparam int NUM_PHASES   = 11;
  localparam int PRESSURE_PH  = 1;
  localparam int SPARE_PH     = 3;
  localparam int QUIET_PH     = 5;
  localparam int HOLD_CYCLES  = 120;
  // Two queued blocks plus the one in the back end, each up to CODE_LEN words.
  localparam int DRAIN_CYCLES = 4 * CODE_LEN + 8;
  localparam int CYCLE_LIMIT  = 100000;

  typedef struct packed {
    logic [SLOT_W-1:0]        slot;
    logic [CODE_W-1:0]        code;
    logic signed [SYM_W-1:0]  symbol;
    logic [SIDX_W-1:0]        index;
    logic                     last;
  } sym_word_t;

  // One row of the opening table: a whole chip block and, where it is obvious,
  // the single symbol word it must produce.
  typedef struct packed {
    logic [CODE_LEN-1:0][CHIP_W-1:0] chips;
    logic                            has_want;
    sym_word_t                       want;
  } chip_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  wcd_chip_if chip_if ();
  wcd_res_if  res_if ();

  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  walsh_code_despreader #(
    .CODE_LEN (CODE_LEN)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (chip_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Correlator model state, mirroring the block's own registers.
  int               corr_acc [MAX_USERS];
  int               blk_chip;
  logic [SIDX_W-1:0] frame_pos;
  logic [MAX_USERS-1:0] live_users;
  logic [FS_W-1:0]  frame_len_reg;

  sym_word_t pending_symbols [$];  // symbol words still owed by the block
  sym_word_t block_words [$];      // words produced by the latest chip

  int fail_count  = 0;
  int chips_taken = 0;   // advanced with nonblocking writes only
  int hold_mark   = -1;  // chip count at which the receiver holds off
  int burst_left  = 1;
  int cycle_count = 0;

  chip_row_t chip_tbl [3];
  logic [FS_W-1:0] fs_plan [NUM_PHASES];

  function automatic logic [PADDR_W-1:0] reg_addr(input logic [REG_IDX_W-1:0] idx);
    return {idx, 2'b00};
  endfunction

  // Sylvester Hadamard sign: row r, column c is negative when r & c has odd parity.
  function automatic bit chip_negated(input int code, input int pos);
    logic [31:0] both;
    both = code & pos;
    return ^both;
  endfunction

  task automatic model_reset();
    foreach (corr_acc[u]) corr_acc[u] = 0;
    blk_chip      = 0;
    frame_pos     = '0;
    live_users    = '0;
    frame_len_reg = FS_W'(FS_RESET);
  endtask

  // Accumulates one chip; on a block's last chip fills block_words with the
  // symbol words of the active users.
  task automatic despread_chip(input logic signed [CHIP_W-1:0] c);
    int q;
    int flen;
    int next_pos;
    sym_word_t w;
    block_words.delete();
    for (int u = 0; u < USERS; u++) begin
      if (chip_negated(u, blk_chip)) corr_acc[u] -= int'(c);
      else corr_acc[u] += int'(c);
    end
    blk_chip++;
    if (blk_chip < CODE_LEN) return;
    blk_chip = 0;
    // The first block of a frame picks the users anew.
    if (frame_pos == 0) live_users = '0;
    for (int u = 0; u < USERS; u++) begin
      q = corr_acc[u] / CODE_LEN;  // truncates toward zero
      corr_acc[u] = 0;
      if (q > 127) q = 127;
      if (q < -128) q = -128;
      if (frame_pos == 0 && q != 0) live_users[u] = 1'b1;
      if (live_users[u]) begin
        w.slot   = SLOT_W'(block_words.size());
        w.code   = CODE_W'(u);
        w.symbol = SYM_W'(q);
        w.index  = frame_pos;
        w.last   = 1'b0;
        block_words.push_back(w);
      end
    end
    if (block_words.size() > 0) block_words[block_words.size()-1].last = 1'b1;
    // A length of zero acts as one, anything past the maximum as the maximum.
    flen = int'(frame_len_reg);
    if (flen == 0) flen = 1;
    if (flen > FRAME_MAX) flen = FRAME_MAX;
    next_pos = int'(frame_pos) + 1;
    frame_pos = (next_pos >= flen) ? '0 : SIDX_W'(next_pos);
  endtask

  // Offers one chip, waits for the handshake, then books what it causes.
  // The sender works in bursts; after each burst valid stays low for a random gap.
  task automatic send_chip(input logic signed [CHIP_W-1:0] c, input logic typed,
                           input sym_word_t typed_word);
    chip_if.valid <= 1'b1;
    chip_if.chip  <= c;
    do @(posedge clk_i); while (!chip_if.ready);
    chips_taken <= chips_taken + 1;
    despread_chip(c);
    if (typed) pending_symbols.push_back(typed_word);
    else foreach (block_words[i]) pending_symbols.push_back(block_words[i]);
    burst_left--;
    if (burst_left == 0) begin
      chip_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 70)
                                               : $urandom_range(1, 20);
    end
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= reg_addr(idx);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_FRAME_SYMBOLS) frame_len_reg = data[FS_W-1:0];
    @(posedge clk_i);
  endtask

  // Reads the frame length back and compares it with the value last written.
  task automatic check_frame_reg();
    logic [APB_DW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(REG_FRAME_SYMBOLS);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== APB_DW'(frame_len_reg)) begin
      $display("%0t: frame_symbols readback expected %0d actual %0d",
               $time, frame_len_reg, got);
      fail_count++;
    end
    @(posedge clk_i);
  endtask

  // Lowers valid, waits for every owed word, then lets blocks that owe
  // nothing clear the pipeline before the register is touched.
  task automatic settle();
    if (chip_if.valid) chip_if.valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Builds one chip block. Mostly the users of the given mask are spread
  // with random amplitudes; the rest is noise, rail-to-rail chips or a
  // different user set, sometimes overdriven so the chips clip. With
  // spread_only set the block is always a plain spread of the mask.
  task automatic make_block(input logic [MAX_USERS-1:0] mask, input bit spread_only,
                            output logic signed [CHIP_W-1:0] blk [CODE_LEN]);
    int pick;
    int span;
    int acc;
    int amp [MAX_USERS];
    logic [MAX_USERS-1:0] users;
    pick  = spread_only ? 5 : $urandom_range(0, 9);
    users = mask;
    if (pick == 2) users = ($urandom_range(0, 3) == 0) ? '0 : MAX_USERS'($urandom());
    users &= USER_BITS;
    span = (pick == 3) ? 127 : 127 / (($countones(users) > 0) ? $countones(users) : 1);
    for (int u = 0; u < MAX_USERS; u++) amp[u] = $urandom_range(0, 2 * span) - span;
    for (int c = 0; c < CODE_LEN; c++) begin
      if (pick == 0) begin
        blk[c] = CHIP_W'($urandom());
      end else if (pick == 1) begin
        blk[c] = $urandom_range(0, 1) ? 8'sh7F : 8'sh80;
      end else begin
        acc = 0;
        for (int u = 0; u < USERS; u++)
          if (users[u]) acc += chip_negated(u, c) ? -amp[u] : amp[u];
        if (acc > 127) acc = 127;
        if (acc < -128) acc = -128;
        blk[c] = CHIP_W'(acc);
      end
    end
  endtask

  // Result side: every accepted word is matched against the oldest one owed.
  task automatic check_symbol_word();
    sym_word_t want;
    if (pending_symbols.size() == 0) begin
      $display("%0t: unexpected word slot %0d code %0d symbol %0d index %0d last %0b",
               $time, res_if.user_slot, res_if.user_code, res_if.symbol,
               res_if.symbol_index, res_if.last);
      fail_count++;
      return;
    end
    want = pending_symbols.pop_front();
    if (res_if.user_slot !== want.slot) begin
      $display("%0t: user_slot expected %0d actual %0d", $time, want.slot, res_if.user_slot);
      fail_count++;
    end
    if (res_if.user_code !== want.code) begin
      $display("%0t: user_code expected %0d actual %0d", $time, want.code, res_if.user_code);
      fail_count++;
    end
    if (res_if.symbol !== want.symbol) begin
      $display("%0t: symbol expected %0d actual %0d", $time, want.symbol, res_if.symbol);
      fail_count++;
    end
    if (res_if.symbol_index !== want.index) begin
      $display("%0t: symbol_index expected %0d actual %0d",
               $time, want.index, res_if.symbol_index);
      fail_count++;
    end
    if (res_if.last !== want.last) begin
      $display("%0t: last expected %0b actual %0b", $time, want.last, res_if.last);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) check_symbol_word();
  end

  // Receiver: switches at random among stall patterns, and
  // once, partway into the pressure phase, holds off long enough for the
  // block queue to fill and the chip input to stall.
  initial begin
    int mode;
    int span_left;
    int hold_left;
    int tick;
    bit hold_done;
    mode      = 0;
    span_left = 0;
    hold_left = 0;
    tick      = 0;
    hold_done = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (!hold_done && chips_taken == hold_mark) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (span_left == 0) begin
        mode      = $urandom_range(0, 3);
        span_left = $urandom_range(20, 80);
      end
      span_left--;
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= $urandom_range(0, 1);
          2: res_if.ready <= ($urandom_range(0, 7) != 0);
          default: res_if.ready <= ((tick % 5) != 0);
        endcase
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int nblk;
    logic [MAX_USERS-1:0] phase_mask;
    logic [APB_DW-1:0] wdata;
    logic signed [CHIP_W-1:0] blk [CODE_LEN];
    sym_word_t none;

    none = '0;
    rst_ni        <= 1'b0;
    chip_if.valid <= 1'b0;
    chip_if.chip  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;

    // After reset the frame holds 16 symbols, so these three blocks are the
    // first of a frame and two more of it. All-max chips make only user 0
    // active at full scale. Alternating max and min leave user 0 a sum of -4,
    // which truncates to zero rather than rounding down. All-min chips give
    // the most negative symbol.
    chip_tbl[0] = '{chips: {CODE_LEN{8'h7F}}, has_want: 1'b1,
                    want: '{slot: 3'd0, code: 3'd0, symbol: 8'sh7F, index: 12'd0, last: 1'b1}};
    chip_tbl[1] = '{chips: {(CODE_LEN/2){8'h80, 8'h7F}}, has_want: 1'b1,
                    want: '{slot: 3'd0, code: 3'd0, symbol: 8'sh00, index: 12'd1, last: 1'b1}};
    chip_tbl[2] = '{chips: {CODE_LEN{8'h80}}, has_want: 1'b1,
                    want: '{slot: 3'd0, code: 3'd0, symbol: 8'sh80, index: 12'd2, last: 1'b1}};

    // Zero and oversized lengths, shrinking below the current position, and
    // a frame of the largest length.
    fs_plan = '{13'd0, 13'd4096, 13'd3, 13'd8191, 13'd2, 13'd1,
                13'd5, 13'd4097, 13'd7, 13'd4096, 13'd16};

    model_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_frame_reg();

    // Mid-block chips owe nothing; the block's last chip owes the typed word.
    foreach (chip_tbl[r])
      for (int c = 0; c < CODE_LEN; c++)
        send_chip(chip_tbl[r].chips[c],
                  chip_tbl[r].has_want && (c == CODE_LEN - 1), chip_tbl[r].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      wdata = $urandom();
      wdata[FS_W-1:0] = fs_plan[p];
      reg_write(REG_FRAME_SYMBOLS, wdata);
      check_frame_reg();
      if (p == SPARE_PH) begin
        reg_write(REG_SPARE, $urandom());
        check_frame_reg();
      end
      if (p == PRESSURE_PH) begin
        nblk       = 8;
        phase_mask = USER_BITS;
        hold_mark  <= chips_taken + 2 * CODE_LEN;
      end else begin
        nblk       = $urandom_range(2, 5);
        phase_mask = (p == QUIET_PH) ? '0 : MAX_USERS'($urandom_range(1, 255));
      end
      for (int b = 0; b < nblk; b++) begin
        // The pressure frame opens with a plain spread so that it has users.
        make_block(phase_mask, (p == PRESSURE_PH) && (b == 0), blk);
        for (int c = 0; c < CODE_LEN; c++) send_chip(blk[c], 1'b0, none);
      end
    end

    settle();
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
